FILE: hw/rtl/fpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum plane culling package
// Shared item types, kind codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fpc_pkg;

    // Fixed field and arithmetic widths.
    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int DIFF_W  = COORD_W + 1;      // coordinate minus plane point
    localparam int PROD_W  = DIFF_W + COORD_W; // one exact product
    localparam int DIST_W  = PROD_W + 2;       // exact sum of three products

    // Item kind codes.
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_SPHERE = 2'd1;
    localparam logic [1:0] KIND_BOX    = 2'd2;

    // One input item.
    typedef struct packed {
        logic [1:0]                 kind;
        logic [2:0]                 plane_index;
        logic signed [COORD_W-1:0]  a_x;
        logic signed [COORD_W-1:0]  a_y;
        logic signed [COORD_W-1:0]  a_z;
        logic signed [COORD_W-1:0]  b_x;
        logic signed [COORD_W-1:0]  b_y;
        logic signed [COORD_W-1:0]  b_z;
        logic [RAD_W-1:0]           radius;
    } fpc_in_t;

    // One result item.
    typedef struct packed {
        logic inside_res;
        logic was_test;
    } fpc_out_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_ISSUE,
        ST_DRAIN,
        ST_REPORT
    } fpc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the accepted item
        logic write_plane; // store a load item into the plane table
        logic issue;       // send the current plane into the distance pipeline
        logic report;      // drive the result for one cycle
    } fpc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_plane;  // the plane counter points at the final plane
        logic pipe_busy;   // a plane is still in flight in the pipeline
    } fpc_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/frustum_plane_culling.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum plane culling
// Tests spheres and axis-aligned boxes against a table of frustum planes.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on item and raise start; the transaction is taken at a rising
//   edge where start is high and busy is low. Kind load writes one plane
//   (point in a_*, inward normal in b_*) into the table; kind sphere and kind
//   box test the object against every plane.
//   Each transaction yields exactly one result on result, valid for the single
//   cycle in which done is high. The receiver has no way to stall it.
// Timing:
//   A load (or an unused kind) reports in the cycle after it is taken. A test
//   issues one stored plane per cycle into a four-stage distance pipeline
//   (difference, multiply, sum, compare), waits for the pipeline to drain and
//   then reports; a new transaction is taken only after the report, since busy
//   stays high until then. The plane walk through the one shared three-product
//   unit sets the time that a test takes.
// Reset:
//   rst_n clears the controller and zeroes the whole plane table; a zero plane
//   passes every test.
// ----------------------------------------------------------------------------
module frustum_plane_culling
    import fpc_pkg::*;
#(
    parameter int NUM_PLANES = 6,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire fpc_in_t item,
    output logic         busy,
    output logic         done,
    output fpc_out_t     result
);

    fpc_cmd_t    cmd;
    fpc_status_t status;

    // Controller.
    fpc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (item.kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Datapath.
    fpc_datapath #(
        .NUM_PLANES (NUM_PLANES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    // A taken transaction makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a transaction was taken");

    // A result ends the transaction: the block is free right after it.
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after reporting");

    // Planes are only in flight while a test is running.
    a_pipe_in_test: assert property (@(posedge clk) disable iff (!rst_n)
        status.pipe_busy |-> (busy && !done))
        else $error("distance pipeline active outside a test");

    // A pass can only be reported for a test result.
    a_inside_is_test: assert property (@(posedge clk) disable iff (!rst_n)
        result.inside_res |-> (done && result.was_test))
        else $error("pass flag raised outside a test result");

endmodule
`default_nettype wire

FILE: hw/rtl/fpc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum plane culling controller
// Sequences one transaction at a time: table writes pass through the write state
// and report, tests issue one plane per cycle, wait for the pipeline to drain, then report.
// ----------------------------------------------------------------------------
module fpc_ctrl
    import fpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  kind,
    input  wire fpc_status_t status,
    output fpc_cmd_t         cmd,
    output logic             busy,
    output logic             done
);

    fpc_state_t state_reg;
    fpc_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind inside {KIND_SPHERE, KIND_BOX})
                    begin
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_ISSUE:
            begin
                if (status.last_plane)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decode.
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_WRITE:
            begin
                cmd.write_plane = 1'b1;
                cmd.report      = 1'b1;
                done            = 1'b1;
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
                busy = 1'b1;
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                done       = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/fpc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum plane culling datapath
// Holds the plane table and a four-stage distance pipeline: difference,
// product, sum, then compare against the limit and fold into the pass flag.
// ----------------------------------------------------------------------------
module fpc_datapath
    import fpc_pkg::*;
#(
    parameter int NUM_PLANES = 6,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire fpc_in_t  item,
    input  wire fpc_cmd_t cmd,
    output fpc_status_t   status,
    output fpc_out_t      result
);

    localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    // Captured item and its comparison limit.
    fpc_in_t                   item_reg;
    logic signed [DIST_W-1:0]  limit_reg;
    logic signed [DIST_W-1:0]  limit_next;
    logic [DIST_W-1:0]         rad_scaled;

    // Plane table.
    logic signed [COORD_W-1:0] pt_x_reg [NUM_PLANES];
    logic signed [COORD_W-1:0] pt_y_reg [NUM_PLANES];
    logic signed [COORD_W-1:0] pt_z_reg [NUM_PLANES];
    logic signed [COORD_W-1:0] nm_x_reg [NUM_PLANES];
    logic signed [COORD_W-1:0] nm_y_reg [NUM_PLANES];
    logic signed [COORD_W-1:0] nm_z_reg [NUM_PLANES];
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_idx;

    // Plane counter.
    logic [IDX_W-1:0]          plane_cnt_reg;

    // Pipeline stages.
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
    logic signed [COORD_W-1:0] rd_nx;
    logic signed [COORD_W-1:0] rd_ny;
    logic signed [COORD_W-1:0] rd_nz;
    logic signed [DIFF_W-1:0]  diff_x_reg;
    logic signed [DIFF_W-1:0]  diff_y_reg;
    logic signed [DIFF_W-1:0]  diff_z_reg;
    logic signed [COORD_W-1:0] nrm_x_reg;
    logic signed [COORD_W-1:0] nrm_y_reg;
    logic signed [COORD_W-1:0] nrm_z_reg;
    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_y_reg;
    logic signed [PROD_W-1:0]  prod_z_reg;
    logic signed [DIST_W-1:0]  sum_reg;
    logic                      s1_valid_reg;
    logic                      s2_valid_reg;
    logic                      s3_valid_reg;
    logic                      ok_reg;
    logic                      is_test;

    // Sphere limit is minus the radius scaled to product units; box limit is zero.
    assign rad_scaled = DIST_W'(item.radius) << FRAC_BITS;
    assign limit_next = (item.kind == KIND_SPHERE) ? -$signed(rad_scaled) : '0;

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg  <= item;
            limit_reg <= limit_next;
        end
    end

    // Plane table write; an index past the table is dropped.
    assign wr_en  = cmd.write_plane && (item_reg.kind == KIND_LOAD) &&
                    (int'(item_reg.plane_index) < NUM_PLANES);
    assign wr_idx = IDX_W'(item_reg.plane_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                pt_x_reg[i] <= '0;
                pt_y_reg[i] <= '0;
                pt_z_reg[i] <= '0;
                nm_x_reg[i] <= '0;
                nm_y_reg[i] <= '0;
                nm_z_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            pt_x_reg[wr_idx] <= item_reg.a_x;
            pt_y_reg[wr_idx] <= item_reg.a_y;
            pt_z_reg[wr_idx] <= item_reg.a_z;
            nm_x_reg[wr_idx] <= item_reg.b_x;
            nm_y_reg[wr_idx] <= item_reg.b_y;
            nm_z_reg[wr_idx] <= item_reg.b_z;
        end
    end

    // Plane counter walks the table while planes are issued.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_cnt_reg <= '0;
        end
        else if (cmd.capture)
        begin
            plane_cnt_reg <= '0;
        end
        else if (cmd.issue)
        begin
            plane_cnt_reg <= plane_cnt_reg + 1'b1;
        end
    end

    // Vertex selection: a box uses the corner farthest along the normal.
    assign rd_nx = nm_x_reg[plane_cnt_reg];
    assign rd_ny = nm_y_reg[plane_cnt_reg];
    assign rd_nz = nm_z_reg[plane_cnt_reg];

    always_comb
    begin
        vx = item_reg.a_x;
        vy = item_reg.a_y;
        vz = item_reg.a_z;
        if (item_reg.kind == KIND_BOX)
        begin
            vx = rd_nx[COORD_W-1] ? item_reg.a_x : item_reg.b_x;
            vy = rd_ny[COORD_W-1] ? item_reg.a_y : item_reg.b_y;
            vz = rd_nz[COORD_W-1] ? item_reg.a_z : item_reg.b_z;
        end
    end

    // Stage one: difference from the plane point.
    always_ff @(posedge clk)
    begin
        diff_x_reg <= DIFF_W'(vx) - DIFF_W'(pt_x_reg[plane_cnt_reg]);
        diff_y_reg <= DIFF_W'(vy) - DIFF_W'(pt_y_reg[plane_cnt_reg]);
        diff_z_reg <= DIFF_W'(vz) - DIFF_W'(pt_z_reg[plane_cnt_reg]);
        nrm_x_reg  <= rd_nx;
        nrm_y_reg  <= rd_ny;
        nrm_z_reg  <= rd_nz;
    end

    // Stage two: exact products.
    always_ff @(posedge clk)
    begin
        prod_x_reg <= diff_x_reg * nrm_x_reg;
        prod_y_reg <= diff_y_reg * nrm_y_reg;
        prod_z_reg <= diff_z_reg * nrm_z_reg;
    end

    // Stage three: exact signed distance.
    always_ff @(posedge clk)
    begin
        sum_reg <= DIST_W'(prod_x_reg) + DIST_W'(prod_y_reg) + DIST_W'(prod_z_reg);
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage four: every plane must leave the distance at or above the limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            ok_reg <= 1'b1;
        end
        else if (s3_valid_reg && (sum_reg < limit_reg))
        begin
            ok_reg <= 1'b0;
        end
    end

    // Status and result.
    assign is_test = (item_reg.kind == KIND_SPHERE) || (item_reg.kind == KIND_BOX);

    assign status.last_plane = (plane_cnt_reg == IDX_W'(NUM_PLANES - 1));
    assign status.pipe_busy  = s1_valid_reg || s2_valid_reg || s3_valid_reg;

    assign result.was_test   = cmd.report && is_test;
    assign result.inside_res = cmd.report && is_test && ok_reg;

endmodule
`default_nettype wire
